@@ rtl/swb_pkg.sv @@
// Shared types, constants and a helper function for the shade-of-gray white balance block.
`timescale 1ns / 1ps
`default_nettype none
package swb_pkg;

	localparam int SAMPLE_W = 8;
	localparam int POW_W    = 48;
	localparam int SUM_W    = 64;
	localparam int WIDE_W   = 128;
	localparam int LIMB_W   = 32;
	localparam int GAIN_W   = 16;
	localparam int COUNT_W  = 17;
	localparam int P_W      = 3;
	localparam int BITS_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_APPLY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NORM_POWER  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 1'b1;

	localparam logic [P_W-1:0]    NORM_POWER_RST  = 3'd6;
	localparam logic [BITS_W-1:0] SAMPLE_BITS_RST = 4'd8;
	localparam logic [GAIN_W-1:0] GAIN_ONE        = 16'd256;
	localparam logic [GAIN_W-1:0] GAIN_MAX        = 16'hFFFF;

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] red_in;
		logic [SAMPLE_W-1:0] green_in;
		logic [SAMPLE_W-1:0] blue_in;
		logic                frame_end;
	} pix_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red_out;
		logic [SAMPLE_W-1:0] green_out;
		logic [SAMPLE_W-1:0] blue_out;
		logic                overflow_flag;
	} res_t;

	// Queue entry after the front has sorted the beat.
	typedef struct packed {
		logic                is_apply;
		logic                last;
		logic [SAMPLE_W-1:0] r;
		logic [SAMPLE_W-1:0] g;
		logic [SAMPLE_W-1:0] b;
	} job_t;

	typedef struct packed {
		logic               start;
		logic [P_W-1:0]     power;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   red_sum;
		logic [SUM_W-1:0]   green_sum;
		logic [SUM_W-1:0]   blue_sum;
	} solve_req_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] red_gain;
		logic [GAIN_W-1:0] blue_gain;
	} solve_rsp_t;

	// Rounded 8.8 gain with clamp to the sample maximum.
	function automatic logic [SAMPLE_W-1:0] scale(input logic [SAMPLE_W-1:0] v,
			input logic [GAIN_W-1:0] gain, input logic [SAMPLE_W:0] maxv);
		logic [SAMPLE_W+GAIN_W:0] prod;
		logic [GAIN_W:0]          r;
		prod = (SAMPLE_W+GAIN_W+1)'(v * gain) + (SAMPLE_W+GAIN_W+1)'(128);
		r = prod[SAMPLE_W+GAIN_W:8];
		if (r > (GAIN_W+1)'(maxv)) begin
			scale = maxv[SAMPLE_W-1:0];
		end else begin
			scale = r[SAMPLE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/swb_front.sv @@
// Front end: accepts pixel beats, sorts them into jobs and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module swb_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              pix_valid,
	output logic             pix_ready,
	input  swb_pkg::pix_t    pix,
	output logic             job_valid,
	input  wire              job_ready,
	output swb_pkg::job_t    job
);

	swb_pkg::job_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;
	swb_pkg::job_t entry;

	always_comb begin
		entry.is_apply = (pix.command == swb_pkg::CMD_APPLY);
		// frame_end means nothing on an apply beat.
		entry.last     = pix.frame_end && (pix.command == swb_pkg::CMD_ACCUM);
		entry.r        = pix.red_in;
		entry.g        = pix.green_in;
		entry.b        = pix.blue_in;
	end

	assign pix_ready = (count_q != 2'd2);
	assign job_valid = (count_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign push      = pix_valid && pix_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/swb_solve.sv @@
// Gain solver: bitwise search for each channel norm, then two restoring divisions.
`timescale 1ns / 1ps
`default_nettype none
module swb_solve (
	input  wire                 clk,
	input  wire                 arst_n,
	input  swb_pkg::solve_req_t req,
	output swb_pkg::solve_rsp_t rsp
);

	typedef enum logic [7:0] {
		V_IDLE  = 8'b00000001,
		V_SETUP = 8'b00000010,
		V_CAND  = 8'b00000100,
		V_MUL   = 8'b00001000,
		V_CMP   = 8'b00010000,
		V_DLOAD = 8'b00100000,
		V_DSTEP = 8'b01000000,
		V_DONE  = 8'b10000000
	} vstate_t;

	vstate_t state_q;

	logic [swb_pkg::SUM_W-1:0]   sum_q [3];
	logic [swb_pkg::COUNT_W-1:0] count_q;
	logic [swb_pkg::P_W-1:0]     p_q;
	logic [1:0]                  ch_q;
	logic [3:0]                  bit_q;
	logic [15:0]                 q_q;
	logic [swb_pkg::WIDE_W-1:0]  lhs_q;
	logic [swb_pkg::WIDE_W-1:0]  rhs_q;
	logic [1:0]                  limb_q;
	logic [15:0]                 carry_q;
	logic [swb_pkg::P_W-1:0]     mcnt_q;
	logic [15:0]                 norm_q [3];
	logic                        div_idx_q;
	logic [24:0]                 num_q;
	logic [15:0]                 rem_q;
	logic [15:0]                 nc_q;
	logic [4:0]                  dcnt_q;
	logic [swb_pkg::GAIN_W-1:0]  red_gain_q;
	logic [swb_pkg::GAIN_W-1:0]  blue_gain_q;

	logic [15:0] cand;
	logic [47:0] mul_t;
	logic        fits;
	logic [15:0] nc_sel;
	logic [16:0] rem_s;
	logic        qbit;
	logic [24:0] num_nx;
	logic [swb_pkg::GAIN_W-1:0] gain_nx;

	always_comb begin
		cand   = q_q | (16'd1 << bit_q);
		mul_t  = 48'(lhs_q[{limb_q, 5'b00000} +: swb_pkg::LIMB_W] * cand) + 48'(carry_q);
		fits   = (lhs_q <= rhs_q);
		nc_sel = div_idx_q ? norm_q[2] : norm_q[0];
		rem_s  = {rem_q, num_q[24]};
		qbit   = (rem_s >= {1'b0, nc_q});
		num_nx = {num_q[23:0], qbit};
		if (nc_q == 16'd0) begin
			gain_nx = swb_pkg::GAIN_ONE;
		end else if (num_nx[24:16] != 9'd0) begin
			gain_nx = swb_pkg::GAIN_MAX;
		end else begin
			gain_nx = num_nx[15:0];
		end
	end

	assign rsp.done      = (state_q == V_DONE);
	assign rsp.red_gain  = red_gain_q;
	assign rsp.blue_gain = blue_gain_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			sum_q[0] <= req.red_sum;
			sum_q[1] <= req.green_sum;
			sum_q[2] <= req.blue_sum;
			count_q  <= req.count;
			p_q      <= req.power;
		end
		unique case (state_q)
			V_SETUP: begin
				rhs_q <= swb_pkg::WIDE_W'(sum_q[ch_q]) << {p_q, 3'b000};
				bit_q <= 4'd15;
				q_q   <= 16'd0;
			end
			V_CAND: begin
				lhs_q   <= swb_pkg::WIDE_W'(count_q);
				limb_q  <= 2'd0;
				carry_q <= 16'd0;
				mcnt_q  <= '0;
			end
			V_MUL: begin
				lhs_q[{limb_q, 5'b00000} +: swb_pkg::LIMB_W] <= mul_t[31:0];
				limb_q <= limb_q + 2'd1;
				if (limb_q == 2'd3) begin
					carry_q <= 16'd0;
					mcnt_q  <= mcnt_q + 3'd1;
				end else begin
					carry_q <= mul_t[47:32];
				end
			end
			V_CMP: begin
				if (fits) begin
					q_q <= cand;
				end
				if (bit_q == 4'd0) begin
					norm_q[ch_q] <= fits ? cand : q_q;
				end else begin
					bit_q <= bit_q - 4'd1;
				end
			end
			V_DLOAD: begin
				num_q  <= 25'({norm_q[1], 8'h00}) + 25'(nc_sel >> 1);
				rem_q  <= 16'd0;
				nc_q   <= nc_sel;
				dcnt_q <= 5'd0;
			end
			V_DSTEP: begin
				rem_q  <= qbit ? 16'(rem_s - {1'b0, nc_q}) : rem_s[15:0];
				num_q  <= num_nx;
				dcnt_q <= dcnt_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= V_IDLE;
			ch_q        <= 2'd0;
			div_idx_q   <= 1'b0;
			red_gain_q  <= swb_pkg::GAIN_ONE;
			blue_gain_q <= swb_pkg::GAIN_ONE;
		end else begin
			unique case (state_q)
				V_IDLE: begin
					if (req.start) begin
						ch_q      <= 2'd0;
						div_idx_q <= 1'b0;
						// An empty frame has zero norms everywhere.
						if (req.count == '0) begin
							red_gain_q  <= swb_pkg::GAIN_ONE;
							blue_gain_q <= swb_pkg::GAIN_ONE;
							state_q     <= V_DONE;
						end else begin
							state_q <= V_SETUP;
						end
					end
				end
				V_SETUP: state_q <= V_CAND;
				V_CAND:  state_q <= V_MUL;
				V_MUL: begin
					if (limb_q == 2'd3 && 3'(mcnt_q + 3'd1) == p_q) begin
						state_q <= V_CMP;
					end
				end
				V_CMP: begin
					if (bit_q != 4'd0) begin
						state_q <= V_CAND;
					end else if (ch_q == 2'd2) begin
						state_q <= V_DLOAD;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= V_SETUP;
					end
				end
				V_DLOAD: state_q <= V_DSTEP;
				V_DSTEP: begin
					if (dcnt_q == 5'd24) begin
						if (div_idx_q) begin
							blue_gain_q <= gain_nx;
							state_q     <= V_DONE;
						end else begin
							red_gain_q <= gain_nx;
							div_idx_q  <= 1'b1;
							state_q    <= V_DLOAD;
						end
					end
				end
				V_DONE: state_q <= V_IDLE;
				default: state_q <= V_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/swb_back.sv @@
// Back end: power sums, frame bookkeeping, gain registers and the apply path.
`timescale 1ns / 1ps
`default_nettype none
module swb_back #(
	parameter int PIXEL_BITS       = 8,
	parameter int MAX_FRAME_PIXELS = 65536,
	parameter int MAX_POWER        = 6
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [swb_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  wire  [swb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  wire                                   job_valid,
	output logic                                  job_ready,
	input  swb_pkg::job_t                         job,
	output logic                                  res_valid,
	input  wire                                   res_ready,
	output swb_pkg::res_t                         res,
	output swb_pkg::solve_req_t                   solve_req,
	input  swb_pkg::solve_rsp_t                   solve_rsp
);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_POW   = 5'b00010,
		B_ACC   = 5'b00100,
		B_START = 5'b01000,
		B_SOLVE = 5'b10000
	} bstate_t;

	bstate_t state_q;

	logic [swb_pkg::P_W-1:0]    norm_power_q;
	logic [swb_pkg::BITS_W-1:0] sample_bits_q;
	logic [swb_pkg::P_W-1:0]    p_eff;
	logic [swb_pkg::BITS_W-1:0] bits_eff;
	logic [swb_pkg::SAMPLE_W:0] maxv;

	logic [swb_pkg::SAMPLE_W-1:0] x_r_q, x_g_q, x_b_q;
	logic [swb_pkg::POW_W-1:0]    pw_r_q, pw_g_q, pw_b_q;
	logic [swb_pkg::P_W-1:0]      k_q;
	logic                         last_q;
	logic [swb_pkg::SUM_W-1:0]    sum_r_q, sum_g_q, sum_b_q;
	logic [swb_pkg::COUNT_W-1:0]  count_q;
	logic                         ovf_q;
	logic [swb_pkg::GAIN_W-1:0]   red_gain_q, blue_gain_q;
	swb_pkg::res_t                res_q;
	logic                         res_valid_q;
	logic                         take;
	logic                         room;

	always_comb begin
		if (norm_power_q == '0) begin
			p_eff = 3'd1;
		end else if (norm_power_q > 3'(MAX_POWER)) begin
			p_eff = 3'(MAX_POWER);
		end else begin
			p_eff = norm_power_q;
		end
		if (sample_bits_q == '0) begin
			bits_eff = 4'd1;
		end else if (sample_bits_q > 4'(PIXEL_BITS)) begin
			bits_eff = 4'(PIXEL_BITS);
		end else begin
			bits_eff = sample_bits_q;
		end
		maxv = 9'((10'd1 << bits_eff) - 10'd1);
	end

	assign room      = !res_valid_q || res_ready;
	assign job_ready = (state_q == B_IDLE) && (!job.is_apply || room);
	assign take      = job_valid && job_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign solve_req.start     = (state_q == B_START);
	assign solve_req.power     = p_eff;
	assign solve_req.count     = count_q;
	assign solve_req.red_sum   = sum_r_q;
	assign solve_req.green_sum = sum_g_q;
	assign solve_req.blue_sum  = sum_b_q;

	always_ff @(posedge clk) begin
		if (take && job.is_apply) begin
			res_q.red_out       <= swb_pkg::scale(job.r, red_gain_q, maxv);
			res_q.green_out     <= swb_pkg::scale(job.g, swb_pkg::GAIN_ONE, maxv);
			res_q.blue_out      <= swb_pkg::scale(job.b, blue_gain_q, maxv);
			res_q.overflow_flag <= ovf_q;
		end
		if (take && !job.is_apply) begin
			x_r_q  <= job.r;
			x_g_q  <= job.g;
			x_b_q  <= job.b;
			pw_r_q <= swb_pkg::POW_W'(job.r);
			pw_g_q <= swb_pkg::POW_W'(job.g);
			pw_b_q <= swb_pkg::POW_W'(job.b);
			k_q    <= 3'd1;
			last_q <= job.last;
		end
		if (state_q == B_POW) begin
			pw_r_q <= swb_pkg::POW_W'(pw_r_q * x_r_q);
			pw_g_q <= swb_pkg::POW_W'(pw_g_q * x_g_q);
			pw_b_q <= swb_pkg::POW_W'(pw_b_q * x_b_q);
			k_q    <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			norm_power_q  <= swb_pkg::NORM_POWER_RST;
			sample_bits_q <= swb_pkg::SAMPLE_BITS_RST;
			sum_r_q       <= '0;
			sum_g_q       <= '0;
			sum_b_q       <= '0;
			count_q       <= '0;
			ovf_q         <= 1'b0;
			red_gain_q    <= swb_pkg::GAIN_ONE;
			blue_gain_q   <= swb_pkg::GAIN_ONE;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					swb_pkg::REG_NORM_POWER:  norm_power_q  <= cfg_wdata[swb_pkg::P_W-1:0];
					swb_pkg::REG_SAMPLE_BITS: sample_bits_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (take && job.is_apply) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (take && !job.is_apply) begin
						state_q <= (p_eff == 3'd1) ? B_ACC : B_POW;
					end
				end
				B_POW: begin
					if (3'(k_q + 3'd1) == p_eff) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					// Pixels past the frame limit are dropped but still flag the frame.
					if (count_q < swb_pkg::COUNT_W'(MAX_FRAME_PIXELS)) begin
						sum_r_q <= sum_r_q + swb_pkg::SUM_W'(pw_r_q);
						sum_g_q <= sum_g_q + swb_pkg::SUM_W'(pw_g_q);
						sum_b_q <= sum_b_q + swb_pkg::SUM_W'(pw_b_q);
						count_q <= count_q + 17'd1;
						if (count_q == '0) begin
							ovf_q <= 1'b0;
						end
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= last_q ? B_START : B_IDLE;
				end
				B_START: begin
					sum_r_q <= '0;
					sum_g_q <= '0;
					sum_b_q <= '0;
					count_q <= '0;
					state_q <= B_SOLVE;
				end
				B_SOLVE: begin
					if (solve_rsp.done) begin
						red_gain_q  <= solve_rsp.red_gain;
						blue_gain_q <= solve_rsp.blue_gain;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/shade_of_gray_white_balance.sv @@
// Top level: front queue, back end and gain solver of the shade-of-gray white balance.
// Apply beat: it passes the front queue register, then the back end's result register;
// back to back applies sustain one per cycle while results are taken and the back end is
// idle, through a two-entry queue in front of the back end. Accumulate beat: occupies the
// back end while B_POW raises each sample to the power p, then B_ACC adds it to the sums.
// Frame end adds the norm search through one 32x16 multiplier, then two gain divisions.
// Reset clears sums, counts, queue; both gains go to 1.0, norm_power to 6, sample_bits to 8.
`timescale 1ns / 1ps
`default_nettype none
module shade_of_gray_white_balance #(
	parameter int PIXEL_BITS       = 8,
	parameter int MAX_FRAME_PIXELS = 65536,
	parameter int MAX_POWER        = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [swb_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire  [swb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire                            pix_valid,
	output logic                           pix_ready,
	input  swb_pkg::pix_t                  pix,
	output logic                           res_valid,
	input  wire                            res_ready,
	output swb_pkg::res_t                  res
);

	logic                job_valid;
	logic                job_ready;
	swb_pkg::job_t       job;
	swb_pkg::solve_req_t solve_req;
	swb_pkg::solve_rsp_t solve_rsp;

	swb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	swb_back #(
		.PIXEL_BITS       (PIXEL_BITS),
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
		.MAX_POWER        (MAX_POWER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.solve_req (solve_req),
		.solve_rsp (solve_rsp)
	);

	swb_solve u_solve (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (solve_req),
		.rsp    (solve_rsp)
	);

endmodule
`default_nettype wire

@@ rtl/swb_checker.sv @@
// Port-level checker for the white balance block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module swb_checker #(
	parameter int PIXEL_BITS = 8
) (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            cfg_we,
	input wire [swb_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input wire [swb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input wire                            res_valid,
	input wire                            res_ready,
	input swb_pkg::res_t                  res
);

	logic [swb_pkg::BITS_W-1:0] bits_q;
	logic [swb_pkg::BITS_W-1:0] bits_eff;
	logic [swb_pkg::SAMPLE_W:0] maxv;

	// Shadow of the sample depth register, to know the clamp limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= swb_pkg::SAMPLE_BITS_RST;
		end else if (cfg_we && cfg_addr == swb_pkg::REG_SAMPLE_BITS) begin
			bits_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (bits_q == '0) begin
			bits_eff = 4'd1;
		end else if (bits_q > 4'(PIXEL_BITS)) begin
			bits_eff = 4'(PIXEL_BITS);
		end else begin
			bits_eff = bits_q;
		end
		maxv = 9'((10'd1 << bits_eff) - 10'd1);
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result payload changed while stalled");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (9'(res.red_out) <= maxv) && (9'(res.green_out) <= maxv)
			&& (9'(res.blue_out) <= maxv))
		else $error("result sample above the configured depth");

endmodule

bind shade_of_gray_white_balance swb_checker #(.PIXEL_BITS(PIXEL_BITS)) u_swb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_addr  (cfg_addr),
	.cfg_wdata (cfg_wdata),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
